// ===== rtl/core/der_pkg.sv =====
`timescale 1ns / 1ps

package der_pkg;

  localparam int DASH_W     = 8;
  localparam int COLOR_W    = 32;
  localparam int CFG_W      = 32;
  localparam int CFG_ADDR_W = 2;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_DASH_EN  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_DASH_LEN = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_GAP_LEN  = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_COLOR    = 2'd3;

  // input opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  typedef logic [3:0] mul_sel_t;
  typedef logic [2:0] dec_op_t;

  // shared multiplier operand pairs
  localparam mul_sel_t MUL_NONE    = 4'd0;
  localparam mul_sel_t MUL_RX_RX   = 4'd1;
  localparam mul_sel_t MUL_RY_RY   = 4'd2;
  localparam mul_sel_t MUL_RX2_RY  = 4'd3;
  localparam mul_sel_t MUL_RY2_X   = 4'd4;
  localparam mul_sel_t MUL_RX2_Y   = 4'd5;
  localparam mul_sel_t MUL_RY2_X5  = 4'd6;
  localparam mul_sel_t MUL_RX2_Y2  = 4'd7;
  localparam mul_sel_t MUL_XX      = 4'd8;
  localparam mul_sel_t MUL_YM1SQ   = 4'd9;
  localparam mul_sel_t MUL_RX2_P   = 4'd10;
  localparam mul_sel_t MUL_RY2_SQ  = 4'd11;
  localparam mul_sel_t MUL_RX2_RY2 = 4'd12;
  localparam mul_sel_t MUL_RX2_Y5  = 4'd13;
  localparam mul_sel_t MUL_RY2_X4  = 4'd14;

  // decision register operations
  localparam dec_op_t DEC_HOLD = 3'd0;
  localparam dec_op_t DEC_INIT = 3'd1;
  localparam dec_op_t DEC_LOAD = 3'd2;
  localparam dec_op_t DEC_ADD  = 3'd3;
  localparam dec_op_t DEC_SUB  = 3'd4;
  localparam dec_op_t DEC_ADDS = 3'd5;

  typedef struct packed {
    mul_sel_t mul_sel;
    dec_op_t  dec_op;
    logic     load_start;
    logic     ld_rx2;
    logic     ld_ry2;
    logic     hold_ld;
    logic     sq_ld;
    logic     init;
    logic     emit;
    logic     inc_x;
    logic     dec_y;
    logic     last;
  } der_cmd_t;

  typedef struct packed {
    logic ge;
    logic dec_neg;
    logic dec_zero;
    logic y_zero;
    logic rad_zero;
  } der_stat_t;

endpackage

// ===== rtl/core/der_dpath.sv =====
`timescale 1ns / 1ps

module der_dpath import der_pkg::*; #(
  parameter int COORD_BITS  = 16,
  parameter int RADIUS_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  der_cmd_t                      cmd,
  output der_stat_t                     stat,
  input  logic signed [COORD_BITS-1:0]  in_center_x,
  input  logic signed [COORD_BITS-1:0]  in_center_y,
  input  logic [RADIUS_BITS-1:0]        in_radius_x,
  input  logic [RADIUS_BITS-1:0]        in_radius_y,
  input  logic                          dash_enable,
  input  logic [DASH_W-1:0]             dash_len,
  input  logic [DASH_W-1:0]             gap_len,
  input  logic [COLOR_W-1:0]            pixel_color,
  output logic signed [COORD_BITS:0]    out_right_x,
  output logic signed [COORD_BITS:0]    out_left_x,
  output logic signed [COORD_BITS:0]    out_lower_y,
  output logic signed [COORD_BITS:0]    out_upper_y,
  output logic                          out_visible,
  output logic                          out_last,
  output logic [COLOR_W-1:0]            out_color
);

  localparam int R     = RADIUS_BITS;
  localparam int C     = COORD_BITS;
  localparam int SQ_W  = 2 * R;
  localparam int X_W   = R + 1;
  localparam int Y_W   = R + 2;
  localparam int MA_W  = 2 * R + 2;
  localparam int MB_W  = 2 * R;
  localparam int P_W   = MA_W + MB_W;
  localparam int DEC_W = 4 * R + 4;
  localparam int OUT_W = C + 1;
  localparam int EXT_W = ((C > R + 2) ? C : R + 2) + 2;

  logic signed [C-1:0]   ctr_x_r, ctr_y_r;
  logic [R-1:0]          rad_x_r, rad_y_r;
  logic [SQ_W-1:0]       rx2_r, ry2_r;
  logic [X_W-1:0]        off_x_r;
  logic signed [Y_W-1:0] off_y_r;
  logic [DEC_W-1:0]      dec_r, dec_nxt;
  logic [P_W-1:0]        prod_r, prod_nxt, hold_r;
  logic [MA_W-1:0]       sq_r;
  logic [DASH_W-1:0]     dash_cnt_r, dash_inc, dash_limit;
  logic                  drawing_r;

  logic [MA_W-1:0] mul_a;
  logic [MB_W-1:0] mul_b;
  logic [R-1:0]    y_mag, ym1_mag;
  logic [MA_W-1:0] x_ext, y_ext, x5, x4, y2, y5_mag;
  logic            y5_neg;
  logic [DEC_W-1:0] prod_ext;

  logic signed [EXT_W-1:0] cx_s, cy_s, ox_s, oy_s;
  logic signed [EXT_W-1:0] rx_sum, lx_sum, ly_sum, uy_sum;

  // offsets are never negative while they feed the multiplier
  assign y_mag   = off_y_r[R-1:0];
  assign ym1_mag = (y_mag == '0) ? R'(1) : y_mag - R'(1);
  assign x_ext   = MA_W'(off_x_r);
  assign y_ext   = MA_W'(y_mag);
  assign x5      = (x_ext << 1) + MA_W'(5);
  assign x4      = (x_ext << 1) + MA_W'(4);
  assign y2      = y_ext << 1;
  // 5 - 2y as sign and magnitude
  assign y5_neg  = (y_mag > R'(2));
  assign y5_mag  = y5_neg ? (y2 - MA_W'(5)) : (MA_W'(5) - y2);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      MUL_RX_RX: begin
        mul_a = MA_W'(rad_x_r);
        mul_b = MB_W'(rad_x_r);
      end
      MUL_RY_RY: begin
        mul_a = MA_W'(rad_y_r);
        mul_b = MB_W'(rad_y_r);
      end
      MUL_RX2_RY: begin
        mul_a = MA_W'(rad_y_r);
        mul_b = rx2_r;
      end
      MUL_RY2_X: begin
        mul_a = x_ext;
        mul_b = ry2_r;
      end
      MUL_RX2_Y: begin
        mul_a = y_ext;
        mul_b = rx2_r;
      end
      MUL_RY2_X5: begin
        mul_a = x5;
        mul_b = ry2_r;
      end
      MUL_RX2_Y2: begin
        mul_a = y2;
        mul_b = rx2_r;
      end
      MUL_XX: begin
        mul_a = x_ext;
        mul_b = MB_W'(off_x_r);
      end
      MUL_YM1SQ: begin
        mul_a = MA_W'(ym1_mag);
        mul_b = MB_W'(ym1_mag);
      end
      MUL_RX2_P: begin
        mul_a = prod_r[MA_W-1:0];
        mul_b = rx2_r;
      end
      MUL_RY2_SQ: begin
        mul_a = sq_r;
        mul_b = ry2_r;
      end
      MUL_RX2_RY2: begin
        mul_a = MA_W'(ry2_r);
        mul_b = rx2_r;
      end
      MUL_RX2_Y5: begin
        mul_a = y5_mag;
        mul_b = rx2_r;
      end
      MUL_RY2_X4: begin
        mul_a = x4;
        mul_b = ry2_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;
  assign prod_ext = DEC_W'(prod_r);

  always_comb begin
    case (cmd.dec_op)
      DEC_INIT: dec_nxt = DEC_W'(ry2_r) - prod_ext + DEC_W'(rx2_r >> 2);
      DEC_LOAD: dec_nxt = prod_ext;
      DEC_ADD:  dec_nxt = dec_r + prod_ext;
      DEC_SUB:  dec_nxt = dec_r - prod_ext;
      DEC_ADDS: dec_nxt = y5_neg ? (dec_r - prod_ext) : (dec_r + prod_ext);
      default:  dec_nxt = dec_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_sel != MUL_NONE) prod_r <= prod_nxt;
    if (cmd.hold_ld) hold_r <= prod_r;
    if (cmd.sq_ld) sq_r <= prod_r[MA_W-1:0] + x_ext;
    if (cmd.ld_rx2) rx2_r <= prod_r[SQ_W-1:0];
    if (cmd.ld_ry2) ry2_r <= prod_r[SQ_W-1:0];
    dec_r <= dec_nxt;
    if (cmd.load_start) begin
      ctr_x_r <= in_center_x;
      ctr_y_r <= in_center_y;
      rad_x_r <= in_radius_x;
      rad_y_r <= in_radius_y;
    end
    if (cmd.init) begin
      off_x_r <= '0;
      off_y_r <= $signed(Y_W'(rad_y_r));
    end else if (cmd.emit) begin
      if (cmd.inc_x) off_x_r <= off_x_r + X_W'(1);
      if (cmd.dec_y) off_y_r <= off_y_r - Y_W'(1);
    end
  end

  // dash pattern
  assign dash_inc   = dash_cnt_r + DASH_W'(1);
  assign dash_limit = drawing_r ? dash_len : gap_len;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dash_cnt_r <= '0;
      drawing_r  <= 1'b1;
    end else if (cmd.init) begin
      dash_cnt_r <= '0;
      drawing_r  <= 1'b1;
    end else if (cmd.emit) begin
      if (dash_inc >= dash_limit) begin
        dash_cnt_r <= '0;
        drawing_r  <= !drawing_r;
      end else begin
        dash_cnt_r <= dash_inc;
      end
    end
  end

  // pixel coordinates from the offsets before this iteration's update
  assign cx_s   = EXT_W'(ctr_x_r);
  assign cy_s   = EXT_W'(ctr_y_r);
  assign ox_s   = $signed(EXT_W'(off_x_r));
  assign oy_s   = EXT_W'(off_y_r);
  assign rx_sum = cx_s + ox_s;
  assign lx_sum = cx_s - ox_s;
  assign ly_sum = cy_s + oy_s;
  assign uy_sum = cy_s - oy_s;

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_right_x <= rx_sum[OUT_W-1:0];
      out_left_x  <= lx_sum[OUT_W-1:0];
      out_lower_y <= ly_sum[OUT_W-1:0];
      out_upper_y <= uy_sum[OUT_W-1:0];
      out_visible <= drawing_r || !dash_enable;
      out_last    <= cmd.last;
      out_color   <= pixel_color;
    end
  end

  assign stat.ge       = (hold_r >= prod_r);
  assign stat.dec_neg  = dec_r[DEC_W-1];
  assign stat.dec_zero = (dec_r == '0);
  assign stat.y_zero   = (off_y_r == '0);
  assign stat.rad_zero = (in_radius_x == '0) || (in_radius_y == '0);

endmodule

// ===== rtl/core/der_ctrl.sv =====
`timescale 1ns / 1ps

module der_ctrl import der_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_op,
  output logic      in_stall,
  input  logic      out_stall,
  output logic      out_valid,
  input  der_stat_t stat,
  output der_cmd_t  cmd
);

  localparam logic [4:0] ST_IDLE     = 5'd0;
  localparam logic [4:0] ST_INIT_RX  = 5'd1;
  localparam logic [4:0] ST_INIT_RY  = 5'd2;
  localparam logic [4:0] ST_INIT_RXY = 5'd3;
  localparam logic [4:0] ST_INIT_DEC = 5'd4;
  localparam logic [4:0] ST_CMP_A    = 5'd5;
  localparam logic [4:0] ST_CMP_B    = 5'd6;
  localparam logic [4:0] ST_CMP_C    = 5'd7;
  localparam logic [4:0] ST_R1_ADD   = 5'd8;
  localparam logic [4:0] ST_R1_ADDY  = 5'd9;
  localparam logic [4:0] ST_R1_SUBY  = 5'd10;
  localparam logic [4:0] ST_SW_1     = 5'd11;
  localparam logic [4:0] ST_SW_2     = 5'd12;
  localparam logic [4:0] ST_SW_3     = 5'd13;
  localparam logic [4:0] ST_SW_4     = 5'd14;
  localparam logic [4:0] ST_SW_5     = 5'd15;
  localparam logic [4:0] ST_SW_6     = 5'd16;
  localparam logic [4:0] ST_R2_START = 5'd17;
  localparam logic [4:0] ST_R2_ADDY  = 5'd18;
  localparam logic [4:0] ST_R2_ADDYX = 5'd19;
  localparam logic [4:0] ST_R2_ADDX  = 5'd20;
  localparam logic [4:0] ST_EMIT     = 5'd21;

  logic [4:0] state_r, state_nxt;
  logic       active_r, active_nxt;
  logic       region_two_r, region_two_nxt;
  logic       step_x_r, step_x_nxt;
  logic       step_y_r, step_y_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt      = state_r;
    active_nxt     = active_r;
    region_two_nxt = region_two_r;
    step_x_nxt     = step_x_r;
    step_y_nxt     = step_y_r;
    out_valid_nxt  = out_valid_r && out_stall;
    cmd            = '0;
    cmd.mul_sel    = MUL_NONE;
    cmd.dec_op     = DEC_HOLD;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_START) begin
            if (stat.rad_zero) begin
              active_nxt = 1'b0;
            end else begin
              cmd.load_start = 1'b1;
              state_nxt      = ST_INIT_RX;
            end
          end else if (active_r) begin
            state_nxt = region_two_r ? ST_R2_START : ST_CMP_A;
          end
        end
      end
      ST_INIT_RX: begin
        cmd.mul_sel = MUL_RX_RX;
        state_nxt   = ST_INIT_RY;
      end
      ST_INIT_RY: begin
        cmd.ld_rx2  = 1'b1;
        cmd.mul_sel = MUL_RY_RY;
        state_nxt   = ST_INIT_RXY;
      end
      ST_INIT_RXY: begin
        cmd.ld_ry2  = 1'b1;
        cmd.mul_sel = MUL_RX2_RY;
        state_nxt   = ST_INIT_DEC;
      end
      ST_INIT_DEC: begin
        cmd.init       = 1'b1;
        cmd.dec_op     = DEC_INIT;
        active_nxt     = 1'b1;
        region_two_nxt = 1'b0;
        state_nxt      = ST_IDLE;
      end
      ST_CMP_A: begin
        cmd.mul_sel = MUL_RY2_X;
        state_nxt   = ST_CMP_B;
      end
      ST_CMP_B: begin
        cmd.hold_ld = 1'b1;
        cmd.mul_sel = MUL_RX2_Y;
        state_nxt   = ST_CMP_C;
      end
      ST_CMP_C: begin
        // region one increment is launched early, dropped if the region flips
        cmd.mul_sel = MUL_RY2_X5;
        step_x_nxt  = 1'b1;
        step_y_nxt  = !stat.dec_neg;
        if (stat.ge) begin
          state_nxt = ST_SW_1;
        end else if (stat.dec_neg) begin
          state_nxt = ST_R1_ADD;
        end else begin
          state_nxt = ST_R1_ADDY;
        end
      end
      ST_R1_ADD: begin
        cmd.dec_op = DEC_ADD;
        state_nxt  = ST_EMIT;
      end
      ST_R1_ADDY: begin
        cmd.dec_op  = DEC_ADD;
        cmd.mul_sel = MUL_RX2_Y2;
        state_nxt   = ST_R1_SUBY;
      end
      ST_R1_SUBY: begin
        cmd.dec_op = DEC_SUB;
        state_nxt  = ST_EMIT;
      end
      ST_SW_1: begin
        cmd.mul_sel = MUL_XX;
        state_nxt   = ST_SW_2;
      end
      ST_SW_2: begin
        cmd.sq_ld   = 1'b1;
        cmd.mul_sel = MUL_YM1SQ;
        state_nxt   = ST_SW_3;
      end
      ST_SW_3: begin
        cmd.mul_sel = MUL_RX2_P;
        state_nxt   = ST_SW_4;
      end
      ST_SW_4: begin
        cmd.dec_op  = DEC_LOAD;
        cmd.mul_sel = MUL_RY2_SQ;
        state_nxt   = ST_SW_5;
      end
      ST_SW_5: begin
        cmd.dec_op  = DEC_ADD;
        cmd.mul_sel = MUL_RX2_RY2;
        state_nxt   = ST_SW_6;
      end
      ST_SW_6: begin
        cmd.dec_op     = DEC_SUB;
        region_two_nxt = 1'b1;
        state_nxt      = ST_R2_START;
      end
      ST_R2_START: begin
        cmd.mul_sel = MUL_RX2_Y5;
        step_y_nxt  = 1'b1;
        if (!stat.dec_neg && !stat.dec_zero) begin
          step_x_nxt = 1'b0;
          state_nxt  = ST_R2_ADDY;
        end else begin
          step_x_nxt = 1'b1;
          state_nxt  = ST_R2_ADDYX;
        end
      end
      ST_R2_ADDY: begin
        cmd.dec_op = DEC_ADDS;
        state_nxt  = ST_EMIT;
      end
      ST_R2_ADDYX: begin
        cmd.dec_op  = DEC_ADDS;
        cmd.mul_sel = MUL_RY2_X4;
        state_nxt   = ST_R2_ADDX;
      end
      ST_R2_ADDX: begin
        cmd.dec_op = DEC_ADD;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.emit      = 1'b1;
          cmd.inc_x     = step_x_r;
          cmd.dec_y     = step_y_r;
          cmd.last      = region_two_r && stat.y_zero;
          out_valid_nxt = 1'b1;
          if (region_two_r && stat.y_zero) active_nxt = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      active_r     <= 1'b0;
      region_two_r <= 1'b0;
      step_x_r     <= 1'b0;
      step_y_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      active_r     <= active_nxt;
      region_two_r <= region_two_nxt;
      step_x_r     <= step_x_nxt;
      step_y_r     <= step_y_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/core/dashed_ellipse_rasterizer.sv =====
// Dashed ellipse rasterizer, midpoint scheme, one iteration per step transaction.
// A start transaction (op 0) loads center and radii and primes the decision term;
// it returns nothing, and a zero radius just leaves the block
// idle. Each step transaction (op 1) returns the four symmetric pixel coordinates
// of the current iteration with a visible flag (dash pattern), the configured
// color and a last flag on the final iteration; steps while idle return nothing.
// All products go through one shared registered multiplier, and the block takes
// no new transaction until the current one has finished its sequence; a step also
// waits as long as the previous result stays stalled in the output register.
// Results sit in that register, so a new transaction is taken while the previous
// result still waits.
// Configuration writes are only legal while idle.
`timescale 1ns / 1ps

module dashed_ellipse_rasterizer import der_pkg::*; #(
  parameter int COORD_BITS  = 16,
  parameter int RADIUS_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write port
  input  logic                          cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0]         cfg_addr,
  input  logic [CFG_W-1:0]              cfg_wdata,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_op,
  input  logic signed [COORD_BITS-1:0]  in_center_x,
  input  logic signed [COORD_BITS-1:0]  in_center_y,
  input  logic [RADIUS_BITS-1:0]        in_radius_x,
  input  logic [RADIUS_BITS-1:0]        in_radius_y,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_BITS:0]    out_right_x,
  output logic signed [COORD_BITS:0]    out_left_x,
  output logic signed [COORD_BITS:0]    out_lower_y,
  output logic signed [COORD_BITS:0]    out_upper_y,
  output logic                          out_visible,
  output logic                          out_last,
  output logic [COLOR_W-1:0]            out_color
);

  // configuration registers
  logic                dash_enable_r;
  logic [DASH_W-1:0]   dash_len_r;
  logic [DASH_W-1:0]   gap_len_r;
  logic [COLOR_W-1:0]  pixel_color_r;

  // controller to datapath
  der_cmd_t  cmd;
  der_stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dash_enable_r <= 1'b0;
      dash_len_r    <= DASH_W'(4);
      gap_len_r     <= DASH_W'(4);
      pixel_color_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_DASH_EN:  dash_enable_r <= cfg_wdata[0];
        CFG_DASH_LEN: dash_len_r    <= cfg_wdata[DASH_W-1:0];
        CFG_GAP_LEN:  gap_len_r     <= cfg_wdata[DASH_W-1:0];
        CFG_COLOR:    pixel_color_r <= cfg_wdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer: start setup, region test, decision updates, result handoff
  der_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  // recurrence state, shared multiplier, dash counter and result register
  der_dpath #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_center_x (in_center_x),
    .in_center_y (in_center_y),
    .in_radius_x (in_radius_x),
    .in_radius_y (in_radius_y),
    .dash_enable (dash_enable_r),
    .dash_len    (dash_len_r),
    .gap_len     (gap_len_r),
    .pixel_color (pixel_color_r),
    .out_right_x (out_right_x),
    .out_left_x  (out_left_x),
    .out_lower_y (out_lower_y),
    .out_upper_y (out_upper_y),
    .out_visible (out_visible),
    .out_last    (out_last),
    .out_color   (out_color)
  );

endmodule

// ===== tb/dashed_ellipse_checker.sv =====
`timescale 1ns / 1ps

module dashed_ellipse_checker import der_pkg::*; #(
  parameter int COORD_BITS  = 16,
  parameter int RADIUS_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [CFG_W-1:0]             cfg_wdata,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic                         in_op,
  input  logic signed [COORD_BITS-1:0] in_center_x,
  input  logic signed [COORD_BITS-1:0] in_center_y,
  input  logic [RADIUS_BITS-1:0]       in_radius_x,
  input  logic [RADIUS_BITS-1:0]       in_radius_y,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic signed [COORD_BITS:0]   out_right_x,
  input  logic signed [COORD_BITS:0]   out_left_x,
  input  logic signed [COORD_BITS:0]   out_lower_y,
  input  logic signed [COORD_BITS:0]   out_upper_y,
  input  logic                         out_visible,
  input  logic                         out_last,
  input  logic [COLOR_W-1:0]           out_color,
  output int                           mismatches,
  output int                           outstanding,
  output int                           pixel_sets
);

  typedef struct {
    logic signed [COORD_BITS:0] right_x;
    logic signed [COORD_BITS:0] left_x;
    logic signed [COORD_BITS:0] lower_y;
    logic signed [COORD_BITS:0] upper_y;
    logic                       visible;
    logic                       last;
    logic [COLOR_W-1:0]         color;
  } pixel_set_t;

  pixel_set_t expected_pixels[$];

  // register copies
  logic               pattern_en;
  logic [DASH_W-1:0]  on_len;
  logic [DASH_W-1:0]  off_len;
  logic [COLOR_W-1:0] ink;

  // tracer state
  logic   tracing;
  logic   second_arc;
  longint org_x, org_y;
  longint a_sq, b_sq;
  longint px, py;
  longint err_term;
  int     run_len;
  logic   pen_down;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    pixel_sets  = 0;
  end

  task automatic clear_state();
    pattern_en = 1'b0;
    on_len     = 8'd4;
    off_len    = 8'd4;
    ink        = '0;
    tracing    = 1'b0;
    second_arc = 1'b0;
    org_x      = 0;
    org_y      = 0;
    a_sq       = 0;
    b_sq       = 0;
    px         = 0;
    py         = 0;
    err_term   = 0;
    run_len    = 0;
    pen_down   = 1'b1;
  endtask

  task automatic trace_ellipse(input logic op, input longint cen_x, input longint cen_y,
                               input longint rad_x, input longint rad_y);
    pixel_set_t ps;
    longint     seg_limit;
    if (op == OP_START) begin
      if (rad_x == 0 || rad_y == 0) begin
        tracing = 1'b0;
      end else begin
        org_x      = cen_x;
        org_y      = cen_y;
        a_sq       = rad_x * rad_x;
        b_sq       = rad_y * rad_y;
        px         = 0;
        py         = rad_y;
        err_term   = b_sq - a_sq * rad_y + a_sq / 4;
        second_arc = 1'b0;
        run_len    = 0;
        pen_down   = 1'b1;
        tracing    = 1'b1;
      end
    end else if (tracing) begin
      // slope passes -1: recompute the error term for the lower arc
      if (!second_arc && b_sq * px >= a_sq * py) begin
        second_arc = 1'b1;
        err_term   = b_sq * (px * px + px) + a_sq * (py - 1) * (py - 1) - a_sq * b_sq;
      end
      ps.right_x = (COORD_BITS+1)'(org_x + px);
      ps.left_x  = (COORD_BITS+1)'(org_x - px);
      ps.lower_y = (COORD_BITS+1)'(org_y + py);
      ps.upper_y = (COORD_BITS+1)'(org_y - py);
      ps.visible = pen_down || !pattern_en;
      ps.color   = ink;
      seg_limit = pen_down ? longint'(on_len) : longint'(off_len);
      run_len   = (run_len + 1) & 8'hFF;
      if (run_len >= seg_limit) begin
        run_len  = 0;
        pen_down = !pen_down;
      end
      if (!second_arc) begin
        px = px + 1;
        if (err_term < 0) begin
          err_term = err_term + b_sq * (2 * px + 3);
        end else begin
          py = py - 1;
          err_term = err_term + b_sq * (2 * px + 3) - a_sq * (2 * py + 2);
        end
        ps.last = 1'b0;
      end else begin
        py = py - 1;
        if (err_term > 0) begin
          err_term = err_term + a_sq * (3 - 2 * py);
        end else begin
          px = px + 1;
          err_term = err_term + b_sq * (2 * px + 2) + a_sq * (3 - 2 * py);
        end
        ps.last = (py < 0);
        if (py < 0) tracing = 1'b0;
      end
      expected_pixels.push_back(ps);
    end
  endtask

  task automatic check_field(input string field, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : monitor
    pixel_set_t want;
    if (!rst_n) begin
      clear_state();
      expected_pixels.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          $error("result transaction with no pixel set pending");
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("right_x", want.right_x, out_right_x);
          check_field("left_x", want.left_x, out_left_x);
          check_field("lower_y", want.lower_y, out_lower_y);
          check_field("upper_y", want.upper_y, out_upper_y);
          check_field("visible", want.visible, out_visible);
          check_field("last", want.last, out_last);
          check_field("color", want.color, out_color);
          pixel_sets++;
        end
      end
      if (in_valid && !in_stall)
        trace_ellipse(in_op, longint'(in_center_x), longint'(in_center_y),
                      longint'(in_radius_x), longint'(in_radius_y));
      if (cfg_wr_en) begin
        case (cfg_addr)
          CFG_DASH_EN:  pattern_en = cfg_wdata[0];
          CFG_DASH_LEN: on_len = cfg_wdata[DASH_W-1:0];
          CFG_GAP_LEN:  off_len = cfg_wdata[DASH_W-1:0];
          CFG_COLOR:    ink = cfg_wdata[COLOR_W-1:0];
          default: ;
        endcase
      end
    end
    outstanding <= expected_pixels.size();
  end

endmodule

// ===== tb/dashed_ellipse_rasterizer_tb.sv =====
`timescale 1ns / 1ps

module dashed_ellipse_rasterizer_tb;
  import der_pkg::*;

  localparam int COORD_BITS     = 16;
  localparam int RADIUS_BITS    = 12;
  localparam int STALL_PCT      = 22;    // chance per cycle that a side idles
  localparam int SETTLE_CYCLES  = 20;    // longer than a region-crossing step
  localparam int WATCHDOG_LIMIT = 1000;  // cycles with no transaction at all
  localparam int PHASE_ITEMS    = 75;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         cfg_wr_en;
  logic [CFG_ADDR_W-1:0]        cfg_addr;
  logic [CFG_W-1:0]             cfg_wdata;
  logic                         in_valid;
  logic                         in_stall;
  logic                         in_op;
  logic signed [COORD_BITS-1:0] in_center_x;
  logic signed [COORD_BITS-1:0] in_center_y;
  logic [RADIUS_BITS-1:0]       in_radius_x;
  logic [RADIUS_BITS-1:0]       in_radius_y;
  logic                         out_valid;
  logic                         out_stall;
  logic signed [COORD_BITS:0]   out_right_x;
  logic signed [COORD_BITS:0]   out_left_x;
  logic signed [COORD_BITS:0]   out_lower_y;
  logic signed [COORD_BITS:0]   out_upper_y;
  logic                         out_visible;
  logic                         out_last;
  logic [COLOR_W-1:0]           out_color;

  int   mismatches;
  int   outstanding;
  int   pixel_sets;
  int   n_starts;
  int   n_steps;
  int   n_settings;
  int   quiet_cycles;
  logic no_idle;

  dashed_ellipse_rasterizer #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_op       (in_op),
    .in_center_x (in_center_x),
    .in_center_y (in_center_y),
    .in_radius_x (in_radius_x),
    .in_radius_y (in_radius_y),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_right_x (out_right_x),
    .out_left_x  (out_left_x),
    .out_lower_y (out_lower_y),
    .out_upper_y (out_upper_y),
    .out_visible (out_visible),
    .out_last    (out_last),
    .out_color   (out_color)
  );

  // watches both channels and the register port, predicts and compares
  dashed_ellipse_checker #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_op       (in_op),
    .in_center_x (in_center_x),
    .in_center_y (in_center_y),
    .in_radius_x (in_radius_x),
    .in_radius_y (in_radius_y),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_right_x (out_right_x),
    .out_left_x  (out_left_x),
    .out_lower_y (out_lower_y),
    .out_upper_y (out_upper_y),
    .out_visible (out_visible),
    .out_last    (out_last),
    .out_color   (out_color),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .pixel_sets  (pixel_sets)
  );

  always #4 clk = ~clk;

  // pixel sink: random back-pressure, none while no_idle is set
  always @(negedge clk) begin
    out_stall <= !no_idle && ($urandom_range(99) < STALL_PCT);
  end

  // watchdog: any transaction or register write restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one input transaction; entered and left at a falling edge
  task automatic send_item(input logic op, input logic signed [COORD_BITS-1:0] cx,
                           input logic signed [COORD_BITS-1:0] cy,
                           input logic [RADIUS_BITS-1:0] rx, input logic [RADIUS_BITS-1:0] ry);
    while (!no_idle && $urandom_range(99) < STALL_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_op       <= op;
    in_center_x <= cx;
    in_center_y <= cy;
    in_radius_x <= rx;
    in_radius_y <= ry;
    // stall sampled at the rising edge is the value before that edge
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (op == OP_START) n_starts++;
    else n_steps++;
  endtask

  // start an ellipse, then step it; step payload fields are don't-care and random
  task automatic draw_ellipse(input logic signed [COORD_BITS-1:0] cx,
                              input logic signed [COORD_BITS-1:0] cy,
                              input logic [RADIUS_BITS-1:0] rx,
                              input logic [RADIUS_BITS-1:0] ry, input int steps);
    send_item(OP_START, cx, cy, rx, ry);
    repeat (steps) send_item(OP_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
                             RADIUS_BITS'($urandom), RADIUS_BITS'($urandom));
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  // only called while the block is idle
  task automatic set_config(input logic en, input logic [DASH_W-1:0] dash,
                            input logic [DASH_W-1:0] gap, input logic [COLOR_W-1:0] rgba);
    write_reg(CFG_DASH_EN, CFG_W'(en));
    write_reg(CFG_DASH_LEN, CFG_W'(dash));
    write_reg(CFG_GAP_LEN, CFG_W'(gap));
    write_reg(CFG_COLOR, CFG_W'(rgba));
    cfg_wr_en <= 1'b0;
    n_settings++;
  endtask

  // wait for every predicted pixel set, then let a start or idle step finish
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // mostly small ellipses run to completion (plus at least a step past the end),
  // some abandoned midway, a few full-range radii, a few zero-radius starts
  task automatic random_ellipses(input int budget);
    int spent;
    int kind;
    int steps;
    logic [RADIUS_BITS-1:0] rx;
    logic [RADIUS_BITS-1:0] ry;
    spent = 0;
    while (spent < budget) begin
      kind = $urandom_range(99);
      if (kind < 8) begin
        rx    = RADIUS_BITS'($urandom);
        ry    = RADIUS_BITS'($urandom);
        steps = $urandom_range(1, 10);
      end else if (kind < 14) begin
        rx    = kind[0] ? '0 : RADIUS_BITS'($urandom);
        ry    = kind[0] ? RADIUS_BITS'($urandom) : '0;
        steps = $urandom_range(0, 2);
      end else begin
        rx = RADIUS_BITS'($urandom_range(1, 12));
        ry = RADIUS_BITS'($urandom_range(1, 12));
        if (kind < 35) steps = $urandom_range(1, rx + ry);
        else steps = rx + ry + $urandom_range(2, 3);
      end
      draw_ellipse(COORD_BITS'($urandom), COORD_BITS'($urandom), rx, ry, steps);
      spent += 1 + steps;
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_addr    = '0;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    in_op       = OP_START;
    in_center_x = '0;
    in_center_y = '0;
    in_radius_x = '0;
    in_radius_y = '0;
    no_idle     = 1'b0;
    n_starts    = 0;
    n_steps     = 0;
    n_settings  = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, with reset register values
    send_item(OP_STEP, 0, 0, 0, 0);            // step straight after reset: idle
    draw_ellipse(32767, -32768, 4095, 4095, 3); // widest radii at the coordinate corners
    draw_ellipse(-32768, 32767, 4095, 1, 2);    // flat: long upper arc
    draw_ellipse(0, 0, 1, 4095, 3);             // tall: crosses into lower arc on the second step
    draw_ellipse(12, 34, 0, 5, 1);              // zero horizontal radius abandons it
    draw_ellipse(-56, 78, 3, 0, 1);             // zero vertical radius
    draw_ellipse(100, -100, 1, 1, 4);           // tiny ellipse, last flag, then idle steps
    draw_ellipse(-1, -1, 5, 3, 4);              // partly drawn ...
    draw_ellipse(0, 0, 0, 0, 1);                // ... then dropped by a zero-radius start
    random_ellipses(60);
    drain();

    // zero dash and gap lengths: pen toggles every iteration
    set_config(1'b1, 8'd0, 8'd0, 32'hFFFF_FFFF);
    random_ellipses(PHASE_ITEMS);
    drain();

    set_config(1'b1, 8'd255, 8'd1, 32'h0000_0000);
    random_ellipses(PHASE_ITEMS);
    drain();

    set_config(1'b1, 8'd1, 8'd255, COLOR_W'($urandom));
    random_ellipses(PHASE_ITEMS);
    drain();

    // dashing off, and a long stretch with no idling on either side
    no_idle = 1'b1;
    set_config(1'b0, 8'd2, 8'd3, COLOR_W'($urandom));
    random_ellipses(PHASE_ITEMS);
    drain();
    no_idle = 1'b0;

    set_config(1'b1, DASH_W'($urandom_range(1, 6)), DASH_W'($urandom_range(0, 6)),
               COLOR_W'($urandom));
    random_ellipses(PHASE_ITEMS);
    drain();

    $display("summary: %0d start and %0d step transactions over %0d register settings",
             n_starts, n_steps, n_settings + 1);
    $display("summary: %0d pixel sets compared", pixel_sets);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== dashed_ellipse_rasterizer.f =====
rtl/core/der_pkg.sv
rtl/core/der_dpath.sv
rtl/core/der_ctrl.sv
rtl/core/dashed_ellipse_rasterizer.sv
tb/dashed_ellipse_checker.sv
tb/dashed_ellipse_rasterizer_tb.sv
